// ===== sv/blbc_pkg.sv =====
package blbc_pkg;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    // Status codes of a result.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    localparam logic [7:0] COUNT_MAX = 8'hff;

    // One tag store entry, kept as a single memory word.
    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic        dv;
        logic [31:0] rtime;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_GET_FIN,
        S_RD,
        S_RMW_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd_scan;
        logic rd_entry;
        logic finish_get;
        logic finish_rmw;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_get;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== sv/blbc_ctrl.sv =====
module blbc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  blbc_pkg::t_dp_stat   i_stat,
    output blbc_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_in_stall
);
    import blbc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_get ? S_SCAN : S_RD;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:   n_state = S_GET_FIN;
            S_GET_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RD:      n_state = S_RMW_FIN;
            S_RMW_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_SCAN:    o_cmd.rd_scan    = 1'b1;
            S_DRAIN:   o_cmd            = '0;
            S_GET_FIN: o_cmd.finish_get = i_stat.out_free;
            S_RD:      o_cmd.rd_entry   = 1'b1;
            S_RMW_FIN: o_cmd.finish_rmw = i_stat.out_free;
            default:   o_cmd            = '0;
        endcase
    end

endmodule

// ===== sv/blbc_dp.sv =====
module blbc_dp #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  blbc_pkg::t_ctrl_cmd  i_cmd,
    output blbc_pkg::t_dp_stat   o_stat,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_device,
    input  logic [31:0]          i_block_number,
    input  logic [4:0]           i_entry_index,
    input  logic [31:0]          i_now_tick,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [4:0]           o_result_index,
    output logic                 o_was_hit,
    output logic                 o_needs_disk_read,
    output logic [1:0]           o_status
);
    import blbc_pkg::*;

    localparam int AW = $clog2(NUM_BUFFERS);

    // Tag store and its per-entry written marks; an unwritten entry reads as zero.
    t_entry              mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_init;
    t_entry              r_q;
    logic                r_q_init;
    logic [AW-1:0]       r_q_addr;
    logic                r_scan_live;

    // Request registers.
    t_op                 r_op;
    logic [7:0]          r_dev;
    logic [31:0]         r_blk;
    logic [4:0]          r_idx;
    logic [31:0]         r_now;

    // Scan trackers.
    logic [AW-1:0]       r_cnt;
    logic                r_found_match;
    logic [AW-1:0]       r_match_idx;
    t_entry              r_match_word;
    logic                r_found_free;
    logic [AW-1:0]       r_victim_idx;
    logic [31:0]         r_oldest;

    // Output register.
    logic                r_o_valid;
    logic [4:0]          r_o_idx;
    logic                r_o_hit;
    logic                r_o_rd;
    t_status             r_o_st;

    t_entry              q_word;
    logic [AW+4:0]       idx_ext;
    logic [AW-1:0]       idx_addr;
    logic                idx_in_range;
    logic [AW-1:0]       rd_addr;
    logic                rd_en;
    logic [31:0]         age_diff;
    logic                is_match;
    logic                is_older;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_entry              wr_data;
    logic [AW-1:0]       fin_idx;
    logic [AW+4:0]       fin_idx_ext;
    logic                fin_hit;
    logic                fin_rd;
    t_status             fin_st;
    logic                fin_load;
    logic [7:0]          cnt_dec;

    assign idx_ext      = {{AW{1'b0}}, r_idx};
    assign idx_addr     = idx_ext[AW-1:0];
    assign idx_in_range = (32'(r_idx) < NUM_BUFFERS);
    assign rd_en        = i_cmd.rd_scan | i_cmd.rd_entry;
    assign rd_addr      = i_cmd.rd_scan ? r_cnt : idx_addr;
    assign q_word       = r_q_init ? r_q : t_entry'('0);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q      <= mem[rd_addr];
            r_q_init <= r_init[rd_addr];
            r_q_addr <= rd_addr;
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= '0;
            r_scan_live <= 1'b0;
        end else begin
            if (wr_en) begin
                r_init[wr_addr] <= 1'b1;
            end
            r_scan_live <= i_cmd.rd_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_op);
            r_dev <= i_device;
            r_blk <= i_block_number;
            r_idx <= i_entry_index;
            r_now <= i_now_tick;
        end
    end

    // Match and victim search, one entry per cycle on registered read data.
    assign age_diff = q_word.rtime - r_oldest;
    assign is_match = (q_word.dev == r_dev) && (q_word.blk == r_blk);
    assign is_older = (q_word.cnt == 8'd0) && (!r_found_free || age_diff[31]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_found_match <= 1'b0;
            r_found_free  <= 1'b0;
        end else if (i_cmd.capture) begin
            r_cnt         <= '0;
            r_found_match <= 1'b0;
            r_found_free  <= 1'b0;
        end else begin
            if (i_cmd.rd_scan) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_scan_live) begin
                if (is_match && !r_found_match) begin
                    r_found_match <= 1'b1;
                    r_match_idx   <= r_q_addr;
                    r_match_word  <= q_word;
                end
                if (is_older) begin
                    r_found_free <= 1'b1;
                    r_victim_idx <= r_q_addr;
                    r_oldest     <= q_word.rtime;
                end
            end
        end
    end

    // Final step: entry update and result.
    assign cnt_dec = q_word.cnt - 8'd1;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_addr;
        wr_data = q_word;
        fin_idx = idx_addr;
        fin_hit = 1'b0;
        fin_rd  = 1'b0;
        fin_st  = ST_OK;
        if (i_cmd.finish_get) begin
            priority if (r_found_match) begin
                fin_idx = r_match_idx;
                fin_hit = 1'b1;
                wr_addr = r_match_idx;
                wr_data = r_match_word;
                if (r_match_word.cnt == COUNT_MAX) begin
                    fin_st = ST_OVERFLOW;
                end else begin
                    wr_en      = 1'b1;
                    wr_data.cnt = r_match_word.cnt + 8'd1;
                    wr_data.dv  = 1'b1;
                    fin_rd      = ~r_match_word.dv;
                end
            end else if (r_found_free) begin
                fin_idx       = r_victim_idx;
                fin_rd        = 1'b1;
                wr_en         = 1'b1;
                wr_addr       = r_victim_idx;
                wr_data.dev   = r_dev;
                wr_data.blk   = r_blk;
                wr_data.cnt   = 8'd1;
                wr_data.dv    = 1'b1;
                wr_data.rtime = '0;
            end else begin
                fin_idx = '0;
                fin_st  = ST_NO_FREE;
            end
        end else if (i_cmd.finish_rmw && idx_in_range) begin
            if (r_op == OP_PIN) begin
                if (q_word.cnt == COUNT_MAX) begin
                    fin_st = ST_OVERFLOW;
                end else begin
                    wr_en       = 1'b1;
                    wr_data.cnt = q_word.cnt + 8'd1;
                end
            end else begin
                if (q_word.cnt == 8'd0) begin
                    fin_st = ST_UNDERFLOW;
                end else begin
                    wr_en       = 1'b1;
                    wr_data.cnt = cnt_dec;
                    if (r_op == OP_RELEASE && cnt_dec == 8'd0) begin
                        wr_data.rtime = r_now;
                    end
                end
            end
        end
    end

    assign fin_load    = i_cmd.finish_get | i_cmd.finish_rmw;
    assign fin_idx_ext = {5'd0, fin_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fin_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            // A request that addresses an entry keeps its own index bits.
            r_o_idx <= i_cmd.finish_rmw ? r_idx : fin_idx_ext[4:0];
            r_o_hit <= fin_hit;
            r_o_rd  <= fin_rd;
            r_o_st  <= fin_st;
        end
    end

    assign o_stat.in_get    = (t_op'(i_op) == OP_GET);
    assign o_stat.scan_last = (r_cnt == AW'(NUM_BUFFERS - 1));
    assign o_stat.out_free  = ~r_o_valid | ~i_out_stall;

    assign o_out_valid       = r_o_valid;
    assign o_result_index    = r_o_idx;
    assign o_was_hit         = r_o_hit;
    assign o_needs_disk_read = r_o_rd;
    assign o_status          = r_o_st;

endmodule

// ===== sv/block_buffer_cache_lru_unit.sv =====
// Channel   Direction  Handshake               Payload
// request   in         i_in_valid/o_in_stall   i_op, i_device, i_block_number,
//                                              i_entry_index, i_now_tick
// result    out        o_out_valid/i_out_stall o_result_index, o_was_hit,
//                                              o_needs_disk_read, o_status
//
// A get passes through S_SCAN, S_DRAIN and S_GET_FIN, reading the tag store one entry per
// cycle in S_SCAN; release, pin and unpin pass through S_RD and S_RMW_FIN.
// One request is in flight at a time: the request side stalls from acceptance until the
// result enters the output register, so the next request cannot be taken before then,
// and that load waits while the previous result is still held there.
// Reset is synchronous and clears the per-entry written marks, so every entry reads as zero.
module block_buffer_cache_lru_unit #(
    parameter int NUM_BUFFERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_device,
    input  logic [31:0] i_block_number,
    input  logic [4:0]  i_entry_index,
    input  logic [31:0] i_now_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_result_index,
    output logic        o_was_hit,
    output logic        o_needs_disk_read,
    output logic [1:0]  o_status
);
    import blbc_pkg::*;

    // The controller sequences each request; the datapath holds the tag store,
    // the scan trackers and the output register.
    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    blbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // During a get the datapath walks every entry, remembering the first tag
    // match and the oldest unreferenced entry; the lowest index wins on ties.
    blbc_dp #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_op              (i_op),
        .i_device          (i_device),
        .i_block_number    (i_block_number),
        .i_entry_index     (i_entry_index),
        .i_now_tick        (i_now_tick),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_result_index    (o_result_index),
        .o_was_hit         (o_was_hit),
        .o_needs_disk_read (o_needs_disk_read),
        .o_status          (o_status)
    );

endmodule

// ===== tb/sv/block_buffer_cache_lru_unit_tb.sv =====
module block_buffer_cache_lru_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import blbc_pkg::*;

    localparam int N_ENTRIES = 32;
    // Longest stretch without any accepted request or result before the run is
    // declared hung. It is far longer than a get and than the long receiver
    // hold-off below, so this leaves a wide margin.
    localparam int HANG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 160;
    localparam int POOL_SIZE = 12;

    typedef struct {
        t_op         op;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [4:0]  idx;
        logic [31:0] tick;
    } t_request;

    typedef struct {
        logic [4:0] slot;
        logic       hit;
        logic       disk_read;
        t_status    status;
    } t_reply;

    // Every input is given a known value from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_op = 2'd0;
    logic [7:0]  i_device = 8'd0;
    logic [31:0] i_block_number = 32'd0;
    logic [4:0]  i_entry_index = 5'd0;
    logic [31:0] i_now_tick = 32'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [4:0]  o_result_index;
    logic        o_was_hit;
    logic        o_needs_disk_read;
    logic [1:0]  o_status;

    block_buffer_cache_lru_unit #(
        .NUM_BUFFERS(N_ENTRIES)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_device(i_device),
        .i_block_number(i_block_number),
        .i_entry_index(i_entry_index),
        .i_now_tick(i_now_tick),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_result_index(o_result_index),
        .o_was_hit(o_was_hit),
        .o_needs_disk_read(o_needs_disk_read),
        .o_status(o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Our own copy of the tag store, updated as each request is accepted.
    logic [7:0]  cache_dev    [N_ENTRIES];
    logic [31:0] cache_blk    [N_ENTRIES];
    logic [7:0]  cache_refs   [N_ENTRIES];
    logic        cache_loaded [N_ENTRIES];
    logic [31:0] cache_stamp  [N_ENTRIES];

    t_request request_backlog[$];
    t_reply   replies_due[$];

    int   mismatches = 0;
    int   idle_cycles = 0;
    logic in_taken = 1'b0;
    logic quiet_tail = 1'b0;
    int   send_gap = 0;
    int   stall_gap = 0;
    int   hold_left = 0;
    int   hold_asked = 0;
    int   hold_served = 0;

    // Works out the reply of one request and applies its effect to the tag
    // store copy.
    function automatic t_reply serve_request(t_op op, logic [7:0] dev, logic [31:0] blk,
                                             logic [4:0] idx, logic [31:0] tick);
        t_reply      r;
        int          hit_at;
        int          victim;
        logic [31:0] oldest;
        logic [31:0] age_gap;
        r.slot = idx;
        r.hit = 1'b0;
        r.disk_read = 1'b0;
        r.status = ST_OK;
        if (op == OP_GET) begin
            // The tag match ignores the loaded mark, and the lowest entry wins.
            hit_at = -1;
            for (int i = N_ENTRIES - 1; i >= 0; i--) begin
                if (cache_dev[i] == dev && cache_blk[i] == blk) begin
                    hit_at = i;
                end
            end
            if (hit_at >= 0) begin
                r.slot = 5'(hit_at);
                r.hit = 1'b1;
                if (cache_refs[hit_at] == COUNT_MAX) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    cache_refs[hit_at] = cache_refs[hit_at] + 8'd1;
                    r.disk_read = !cache_loaded[hit_at];
                    cache_loaded[hit_at] = 1'b1;
                end
            end else begin
                // Victim is the free entry released longest ago, where ages
                // are compared modulo 2**32, ties going to the lowest entry.
                victim = -1;
                oldest = '1;
                for (int i = 0; i < N_ENTRIES; i++) begin
                    if (cache_refs[i] == 8'd0) begin
                        age_gap = cache_stamp[i] - oldest;
                        if (victim < 0 || age_gap[31]) begin
                            victim = i;
                            oldest = cache_stamp[i];
                        end
                    end
                end
                if (victim < 0) begin
                    r.slot = 5'd0;
                    r.status = ST_NO_FREE;
                end else begin
                    cache_dev[victim] = dev;
                    cache_blk[victim] = blk;
                    cache_refs[victim] = 8'd1;
                    cache_stamp[victim] = 32'd0;
                    cache_loaded[victim] = 1'b1;
                    r.slot = 5'(victim);
                    r.disk_read = 1'b1;
                end
            end
        end else if (int'(idx) < N_ENTRIES) begin
            if (op == OP_PIN) begin
                if (cache_refs[idx] == COUNT_MAX) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    cache_refs[idx] = cache_refs[idx] + 8'd1;
                end
            end else if (cache_refs[idx] == 8'd0) begin
                r.status = ST_UNDERFLOW;
            end else begin
                cache_refs[idx] = cache_refs[idx] - 8'd1;
                // Only a release that frees the entry stamps the time.
                if (op == OP_RELEASE && cache_refs[idx] == 8'd0) begin
                    cache_stamp[idx] = tick;
                end
            end
        end
        return r;
    endfunction

    task automatic report_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic push_request(t_op op, logic [7:0] dev, logic [31:0] blk,
                                logic [4:0] idx, logic [31:0] tick);
        t_request q;
        q.op = op;
        q.dev = dev;
        q.blk = blk;
        q.idx = idx;
        q.tick = tick;
        request_backlog.push_back(q);
    endtask

    // Holds the sender back until every request has gone in and every reply
    // has come out.
    task automatic drain_cache();
        while (request_backlog.size() != 0 || i_in_valid || replies_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Scoreboard. The reply leaving at this edge always belongs to an older
    // request, so it is checked before the request accepted at the same edge
    // is predicted.
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $display("%0t ns: unexpected reply, expected none, actual index %0d status %0d",
                             $time, o_result_index, o_status);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    report_field("result_index", want.slot, o_result_index);
                    report_field("was_hit", want.hit, o_was_hit);
                    report_field("needs_disk_read", want.disk_read, o_needs_disk_read);
                    report_field("status", want.status, o_status);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                replies_due.push_back(serve_request(t_op'(i_op), i_device, i_block_number,
                                                    i_entry_index, i_now_tick));
            end
        end
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // Watchdog: counts cycles in which neither channel moves anything.
    always @(posedge i_clk) begin : watch_progress
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, HANG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Request driver. A valid request is held unchanged until it is taken;
    // otherwise the next one is loaded from the backlog unless an idle burst
    // is under way.
    always @(negedge i_clk) begin : drive_requests
        t_request nxt;
        logic     drive_valid;
        drive_valid = i_in_valid;
        if (!i_rst_n) begin
            drive_valid = 1'b0;
        end else if (!i_in_valid || in_taken) begin
            drive_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 6);
            end else if (request_backlog.size() != 0) begin
                nxt = request_backlog.pop_front();
                i_op <= nxt.op;
                i_device <= nxt.dev;
                i_block_number <= nxt.blk;
                i_entry_index <= nxt.idx;
                i_now_tick <= nxt.tick;
                drive_valid = 1'b1;
            end
        end
        i_in_valid <= drive_valid;
    end

    // Reply receiver. Besides short random stall bursts it can be asked for
    // one long hold-off, which it counts out here, so that the block fills up
    // and has to stall its request side.
    always @(negedge i_clk) begin : drive_stall
        logic stall_next;
        stall_next = 1'b0;
        if (!i_rst_n) begin
            stall_next = 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            stall_next = 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap--;
            stall_next = 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            stall_gap = $urandom_range(0, 6);
            stall_next = 1'b1;
        end
        i_out_stall <= stall_next;
    end

    initial begin : run_test
        logic [7:0]  pool_dev [POOL_SIZE];
        logic [31:0] pool_blk [POOL_SIZE];
        int          busy[$];
        int          pick;
        int          k;
        int          free_cnt;
        int          sat_slot;
        logic [31:0] clock_tick;
        logic [31:0] tick;
        logic [4:0]  idx;

        for (int i = 0; i < N_ENTRIES; i++) begin
            cache_dev[i] = 8'd0;
            cache_blk[i] = 32'd0;
            cache_refs[i] = 8'd0;
            cache_loaded[i] = 1'b0;
            cache_stamp[i] = 32'd0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_dev[i] = 8'($urandom);
            pool_blk[i] = $urandom;
        end
        // The tick counter starts just short of the wrap so that release
        // stamps cross zero during the random part.
        clock_tick = 32'hffff_0000 | 32'($urandom_range(0, 65535));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. After reset every entry is tagged device 0 block 0,
        // so the first get hits entry 0 and still asks for a disk read.
        push_request(OP_GET, 8'h00, 32'h0000_0000, 5'd31, 32'hffff_ffff);
        push_request(OP_GET, 8'hff, 32'hffff_ffff, 5'd0, 32'd0);
        push_request(OP_GET, 8'h00, 32'h0000_0000, 5'd10, 32'h5555_5555);
        push_request(OP_UNPIN, 8'h55, 32'h5555_5555, 5'd5, 32'd0);
        push_request(OP_RELEASE, 8'haa, 32'haaaa_aaaa, 5'd5, 32'h1234_5678);
        push_request(OP_PIN, 8'h00, 32'd0, 5'd31, 32'd0);
        push_request(OP_RELEASE, 8'h00, 32'd0, 5'd31, 32'hffff_ffff);
        push_request(OP_RELEASE, 8'h00, 32'd0, 5'd0, 32'h8000_0000);
        push_request(OP_RELEASE, 8'h00, 32'd0, 5'd0, 32'h7fff_ffff);
        push_request(OP_RELEASE, 8'h00, 32'd0, 5'd1, 32'h0000_0000);
        // Entry 31 was stamped all ones, which counts as older than zero once
        // the wrap is taken into account, so it is the victim here.
        push_request(OP_GET, 8'h12, 32'ha5a5_a5a5, 5'd21, 32'd0);
        // Entry 0 is free but still tagged, so this is a hit with valid data.
        push_request(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
        push_request(OP_PIN, 8'haa, 32'h5555_5555, 5'd0, 32'd0);
        push_request(OP_UNPIN, 8'h55, 32'haaaa_aaaa, 5'd0, 32'd0);
        push_request(OP_UNPIN, 8'h00, 32'd0, 5'd0, 32'd0);
        push_request(OP_UNPIN, 8'h00, 32'd0, 5'd0, 32'd0);
        push_request(OP_GET, 8'hff, 32'hffff_ffff, 5'd10, 32'd0);
        push_request(OP_PIN, 8'h00, 32'd0, 5'd21, 32'hdead_beef);
        push_request(OP_RELEASE, 8'h00, 32'd0, 5'd21, 32'h0000_0001);
        push_request(OP_RELEASE, 8'h00, 32'd0, 5'd21, 32'h0000_0001);

        // Count saturation: bring one entry up to the maximum count, then
        // check that both a pin and a get hit report overflow and change
        // nothing, and bring the count back down.
        drain_cache();
        push_request(OP_GET, 8'h3c, 32'h0bad_f00d, 5'd0, 32'd0);
        drain_cache();
        sat_slot = 0;
        for (int i = N_ENTRIES - 1; i >= 0; i--) begin
            if (cache_dev[i] == 8'h3c && cache_blk[i] == 32'h0bad_f00d) begin
                sat_slot = i;
            end
        end
        repeat (int'(COUNT_MAX) - 1) begin
            push_request(OP_PIN, 8'($urandom), $urandom, 5'(sat_slot), $urandom);
        end
        push_request(OP_PIN, 8'($urandom), $urandom, 5'(sat_slot), $urandom);
        push_request(OP_GET, 8'h3c, 32'h0bad_f00d, 5'($urandom), $urandom);
        repeat (int'(COUNT_MAX) - 1) begin
            push_request(OP_UNPIN, 8'($urandom), $urandom, 5'(sat_slot), $urandom);
        end
        push_request(OP_RELEASE, 8'($urandom), $urandom, 5'(sat_slot), 32'h8000_0000);

        // Full cache: reference every free entry with fresh blocks, then one
        // more miss finds no free buffer. Afterwards everything is released.
        drain_cache();
        free_cnt = 0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (cache_refs[i] == 8'd0) begin
                free_cnt++;
            end
        end
        for (k = 0; k <= free_cnt; k++) begin
            push_request(OP_GET, 8'hee, 32'hf000_0000 | 32'(k), 5'($urandom), $urandom);
        end
        drain_cache();
        for (int i = 0; i < N_ENTRIES; i++) begin
            repeat (int'(cache_refs[i])) begin
                clock_tick += $urandom_range(1, 3000);
                push_request(OP_RELEASE, 8'($urandom), $urandom, 5'(i), clock_tick);
            end
        end

        // Random part. Gets mostly reuse a small pool of blocks so that hits,
        // retagging and reuse of recently released entries all occur; release,
        // pin and unpin mostly address entries that are in use.
        for (int n = 0; n < 300; n++) begin
            while (request_backlog.size() != 0) begin
                @(posedge i_clk);
            end
            if (n == 100) begin
                hold_asked++;
            end
            if (n == 200) begin
                drain_cache();
            end
            if (n == 260) begin
                quiet_tail = 1'b1;
            end
            clock_tick += $urandom_range(1, 3000);
            tick = ($urandom_range(0, 9) == 0) ? 32'($urandom) : clock_tick;
            pick = $urandom_range(0, 99);
            if (pick < 37) begin
                k = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 99) < 65) begin
                    push_request(OP_GET, pool_dev[k], pool_blk[k], 5'($urandom), tick);
                end else begin
                    if ($urandom_range(0, 1) == 0) begin
                        pool_dev[k] = 8'($urandom);
                        pool_blk[k] = $urandom;
                    end
                    push_request(OP_GET, 8'($urandom), $urandom, 5'($urandom), tick);
                end
            end else begin
                busy.delete();
                for (int i = 0; i < N_ENTRIES; i++) begin
                    if (cache_refs[i] != 8'd0) begin
                        busy.push_back(i);
                    end
                end
                if (busy.size() != 0 && $urandom_range(0, 99) < 85) begin
                    idx = 5'(busy[$urandom_range(0, busy.size() - 1)]);
                end else begin
                    idx = 5'($urandom);
                end
                if (pick < 77) begin
                    push_request(OP_RELEASE, 8'($urandom), $urandom, idx, tick);
                end else if (pick < 85) begin
                    push_request(OP_PIN, 8'($urandom), $urandom, idx, tick);
                end else begin
                    push_request(OP_UNPIN, 8'($urandom), $urandom, idx, tick);
                end
            end
        end

        drain_cache();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
